// File: hdl/kpa_pkg.sv
// Shared types and constants for the keypad alarm controller.
// No dependencies; imported by every module of the block.
package kpa_pkg;

  localparam logic [2:0] KIND_KEY   = 3'd0;
  localparam logic [2:0] KIND_SOUND = 3'd1;
  localparam logic [2:0] KIND_ECHO  = 3'd2;
  localparam logic [2:0] KIND_TICK  = 3'd3;
  localparam logic [2:0] KIND_IDLE  = 3'd4;

  localparam logic [3:0] KEY_A = 4'd3;

  localparam logic [15:0] NEAR_LIMIT_RESET = 16'd888;

  typedef enum logic [1:0] {
    MODE_SET_CODE  = 2'd0,
    MODE_UNARMED   = 2'd1,
    MODE_ARMED     = 2'd2,
    MODE_TRIGGERED = 2'd3
  } mode_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  key_index;
    logic [15:0] echo_width_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0] alarm_mode;
    logic       led_on;
    logic       buzzer_on;
    logic       mic_enabled;
    logic       backlight;
    logic       digit_taken;
    logic       code_wrong;
    logic       entry_open;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } digit_t;

  // keypad layout: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D
  function automatic digit_t key_digit(input logic [3:0] key);
    digit_t d;
    d = '{valid: 1'b1, value: 4'd0};
    case (key)
      4'd0:    d.value = 4'd1;
      4'd1:    d.value = 4'd2;
      4'd2:    d.value = 4'd3;
      4'd4:    d.value = 4'd4;
      4'd5:    d.value = 4'd5;
      4'd6:    d.value = 4'd6;
      4'd8:    d.value = 4'd7;
      4'd9:    d.value = 4'd8;
      4'd10:   d.value = 4'd9;
      4'd13:   d.value = 4'd0;
      default: d.valid = 1'b0;
    endcase
    return d;
  endfunction

endpackage

// File: hdl/kpa_core.sv
// Mode machine and code storage of the keypad alarm controller.
// Depends on kpa_pkg; updates its state on each word that advances.
module kpa_core
  import kpa_pkg::*;
#(
  parameter int CODE_DIGITS = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_item_t  item,
  input  logic [15:0] near_limit,
  output out_item_t result
);

  localparam int CW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam logic [CW-1:0] LAST = CW'(CODE_DIGITS - 1);

  mode_t mode, mode_next;
  logic [CW-1:0] count, count_next;
  logic entering, entering_next;
  logic led, led_next;
  logic buzzer, buzzer_next;
  logic mic, mic_next;
  logic backlight, backlight_next;
  logic store_we, entry_we;
  logic taken, wrong, match;
  digit_t dig;

  logic [3:0] stored_code  [CODE_DIGITS];
  logic [3:0] entered_code [CODE_DIGITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_SET_CODE;
      count     <= '0;
      entering  <= 1'b0;
      led       <= 1'b0;
      buzzer    <= 1'b0;
      mic       <= 1'b0;
      backlight <= 1'b1;
    end else if (fire) begin
      mode      <= mode_next;
      count     <= count_next;
      entering  <= entering_next;
      led       <= led_next;
      buzzer    <= buzzer_next;
      mic       <= mic_next;
      backlight <= backlight_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && store_we) begin
      stored_code[count] <= dig.value;
    end
    if (fire && entry_we) begin
      entered_code[count] <= dig.value;
    end
  end

  assign dig = key_digit(item.key_index);

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (i == CODE_DIGITS - 1) begin
        if (dig.value != stored_code[i]) match = 1'b0;
      end else begin
        if (entered_code[i] != stored_code[i]) match = 1'b0;
      end
    end
  end

  always_comb begin
    mode_next      = mode;
    count_next     = count;
    entering_next  = entering;
    led_next       = led;
    buzzer_next    = buzzer;
    mic_next       = mic;
    backlight_next = backlight;
    store_we       = 1'b0;
    entry_we       = 1'b0;
    taken          = 1'b0;
    wrong          = 1'b0;
    case (item.kind)
      KIND_KEY: begin
        backlight_next = 1'b1;
        if (mode == MODE_SET_CODE) begin
          if (dig.valid) begin
            store_we = 1'b1;
            taken    = 1'b1;
            if (count == LAST) begin
              count_next = '0;
              mode_next  = MODE_UNARMED;
            end else begin
              count_next = count + 1'b1;
            end
          end
        end else if (entering) begin
          if (dig.valid) begin
            entry_we = 1'b1;
            taken    = 1'b1;
            if (count == LAST) begin
              count_next    = '0;
              entering_next = 1'b0;
              if (match) begin
                if (mode == MODE_UNARMED) begin
                  mode_next = MODE_ARMED;
                  mic_next  = 1'b1;
                end else begin
                  if (mode == MODE_TRIGGERED) begin
                    buzzer_next = 1'b0;
                    led_next    = 1'b0;
                  end
                  mode_next = MODE_UNARMED;
                end
              end else begin
                wrong = 1'b1;
              end
            end else begin
              count_next = count + 1'b1;
            end
          end
        end else if (item.key_index == KEY_A) begin
          entering_next = 1'b1;
        end
      end
      KIND_SOUND, KIND_ECHO: begin
        if (item.kind == KIND_SOUND) mic_next = 1'b0;
        if (mode == MODE_ARMED &&
            (item.kind == KIND_SOUND || item.echo_width_us <= near_limit)) begin
          mode_next     = MODE_TRIGGERED;
          led_next      = 1'b1;
          buzzer_next   = 1'b1;
          mic_next      = 1'b0;
          count_next    = '0;
          entering_next = 1'b0;
        end
      end
      KIND_TICK: begin
        if (mode == MODE_TRIGGERED) led_next = ~led;
      end
      KIND_IDLE: begin
        if (backlight) begin
          backlight_next = 1'b0;
          count_next     = '0;
          entering_next  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result.alarm_mode  = mode_next;
    result.led_on      = led_next;
    result.buzzer_on   = buzzer_next;
    result.mic_enabled = mic_next;
    result.backlight   = backlight_next;
    result.digit_taken = taken;
    result.code_wrong  = wrong;
    result.entry_open  = entering_next;
  end

endmodule

// File: hdl/keypad_alarm_controller_top.sv
// An accepted word waits in the input register; its result is registered into out_word.
// Throughput: one word per cycle; in_stall rises only while out_stall holds
// a full output register and a full input register.
// Reset (rst, synchronous, active high): set-code mode, backlight on,
// LED/buzzer/microphone off, near echo limit 888, both stages empty.
// Top level of the keypad alarm controller: input register, mode machine,
// result register and the echo limit register. Depends on kpa_pkg, kpa_core.
module keypad_alarm_controller_top
  import kpa_pkg::*;
#(
  parameter int CODE_DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic        s1_valid;
  in_item_t    s1_item;
  logic        advance;
  logic [15:0] near_limit;
  out_item_t   result;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_limit <= NEAR_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      near_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_word;
    end
  end

  kpa_core #(
    .CODE_DIGITS(CODE_DIGITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .item       (s1_item),
    .near_limit (near_limit),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

endmodule

// File: hdl/kpa_checker.sv
// Port-level checks for the keypad alarm controller, bound to the top level.
// Depends on kpa_pkg and keypad_alarm_controller_top.
module kpa_checker
  import kpa_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  a_buzzer_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.buzzer_on == (out_word.alarm_mode == MODE_TRIGGERED))
    else $error("buzzer level disagrees with triggered mode");

  a_wrong_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.code_wrong |->
      out_word.digit_taken && !out_word.entry_open && out_word.backlight)
    else $error("wrong code flagged without a closing digit");

  a_progress: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_word.kind == in_word.kind) ##1 !out_stall |=> out_valid)
    else $error("accepted word did not reach the output");

endmodule

bind keypad_alarm_controller_top kpa_checker u_kpa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

// File: tb/keypad_alarm_controller_top_test.sv
`timescale 1ns / 100ps
// Testbench for keypad_alarm_controller_top: directed and random event words checked
// against a cycle-free prediction of the alarm panel. Depends on kpa_pkg and the block RTL.
module keypad_alarm_controller_top_test;
  import kpa_pkg::*;

  localparam int CODE_LEN       = 4;
  localparam int LONG_HOLD      = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 1450;

  localparam logic [3:0] KEY_B    = 4'd7;
  localparam logic [3:0] KEY_C    = 4'd11;
  localparam logic [3:0] KEY_STAR = 4'd12;
  localparam logic [3:0] KEY_HASH = 4'd14;
  localparam logic [3:0] KEY_D    = 4'd15;
  localparam logic [3:0] NO_DIGIT = 4'hf;
  localparam logic [2:0] KIND_SPARE = 3'd7;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  keypad_alarm_controller_top #(.CODE_DIGITS(CODE_LEN)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // panel state as predicted
  mode_t       panel_mode;
  logic [3:0]  code_set [CODE_LEN];
  logic [3:0]  code_typed [CODE_LEN];
  int          digit_cnt;
  logic        entry_st;
  logic        led_st;
  logic        buzzer_st;
  logic        mic_st;
  logic        backlight_st;
  logic [15:0] near_limit;

  out_item_t   expected_panel [$];
  int          mismatch_count = 0;
  int          words_sent = 0;
  int          quiet_cycles = 0;
  logic        idling_on = 1'b1;
  logic        hold_req = 1'b0;

  function automatic logic [3:0] key_value(logic [3:0] key);
    case (key)
      4'd0:    return 4'd1;
      4'd1:    return 4'd2;
      4'd2:    return 4'd3;
      4'd4:    return 4'd4;
      4'd5:    return 4'd5;
      4'd6:    return 4'd6;
      4'd8:    return 4'd7;
      4'd9:    return 4'd8;
      4'd10:   return 4'd9;
      4'd13:   return 4'd0;
      default: return NO_DIGIT;
    endcase
  endfunction

  function automatic logic [3:0] digit_key(logic [3:0] d);
    case (d)
      4'd0:    return 4'd13;
      4'd1:    return 4'd0;
      4'd2:    return 4'd1;
      4'd3:    return 4'd2;
      4'd4:    return 4'd4;
      4'd5:    return 4'd5;
      4'd6:    return 4'd6;
      4'd7:    return 4'd8;
      4'd8:    return 4'd9;
      default: return 4'd10;
    endcase
  endfunction

  function automatic logic [3:0] pick_non_digit_key();
    case ($urandom_range(0, 5))
      0:       return KEY_A;
      1:       return KEY_B;
      2:       return KEY_C;
      3:       return KEY_STAR;
      4:       return KEY_HASH;
      default: return KEY_D;
    endcase
  endfunction

  function automatic void trip_alarm();
    panel_mode = MODE_TRIGGERED;
    led_st     = 1'b1;
    buzzer_st  = 1'b1;
    mic_st     = 1'b0;
    digit_cnt  = 0;
    entry_st   = 1'b0;
  endfunction

  function automatic out_item_t predict_panel(in_item_t w);
    out_item_t  r;
    logic [3:0] d;
    logic       taken;
    logic       wrong;
    logic       same;
    int         i;
    taken = 1'b0;
    wrong = 1'b0;
    d = key_value(w.key_index);
    case (w.kind)
      KIND_KEY: begin
        backlight_st = 1'b1;
        if (digit_cnt >= CODE_LEN) digit_cnt = 0;
        if (panel_mode == MODE_SET_CODE) begin
          if (d != NO_DIGIT) begin
            code_set[digit_cnt] = d;
            taken = 1'b1;
            digit_cnt++;
            if (digit_cnt == CODE_LEN) begin
              digit_cnt = 0;
              panel_mode = MODE_UNARMED;
            end
          end
        end else if (entry_st) begin
          if (d != NO_DIGIT) begin
            code_typed[digit_cnt] = d;
            taken = 1'b1;
            digit_cnt++;
            if (digit_cnt == CODE_LEN) begin
              digit_cnt = 0;
              entry_st = 1'b0;
              same = 1'b1;
              for (i = 0; i < CODE_LEN; i++)
                if (code_typed[i] !== code_set[i]) same = 1'b0;
              if (!same) begin
                wrong = 1'b1;
              end else if (panel_mode == MODE_UNARMED) begin
                panel_mode = MODE_ARMED;
                mic_st = 1'b1;
              end else begin
                if (panel_mode == MODE_TRIGGERED) begin
                  buzzer_st = 1'b0;
                  led_st = 1'b0;
                end
                panel_mode = MODE_UNARMED;
              end
            end
          end
        end else if (w.key_index == KEY_A) begin
          entry_st = 1'b1;
        end
      end
      KIND_SOUND: begin
        mic_st = 1'b0;
        if (panel_mode == MODE_ARMED) trip_alarm();
      end
      KIND_ECHO: begin
        if (panel_mode == MODE_ARMED && w.echo_width_us <= near_limit) trip_alarm();
      end
      KIND_TICK: begin
        if (panel_mode == MODE_TRIGGERED) led_st = !led_st;
      end
      KIND_IDLE: begin
        if (backlight_st) begin
          backlight_st = 1'b0;
          digit_cnt = 0;
          entry_st = 1'b0;
        end
      end
      default: ;
    endcase
    r.alarm_mode  = panel_mode;
    r.led_on      = led_st;
    r.buzzer_on   = buzzer_st;
    r.mic_enabled = mic_st;
    r.backlight   = backlight_st;
    r.digit_taken = taken;
    r.code_wrong  = wrong;
    r.entry_open  = entry_st;
    return r;
  endfunction

  function automatic string show_panel(out_item_t p);
    return $sformatf("mode %0d led %b buzzer %b mic %b backlight %b taken %b wrong %b entry %b",
                     p.alarm_mode, p.led_on, p.buzzer_on, p.mic_enabled, p.backlight,
                     p.digit_taken, p.code_wrong, p.entry_open);
  endfunction

  task automatic reset_panel();
    int i;
    panel_mode   = MODE_SET_CODE;
    for (i = 0; i < CODE_LEN; i++) begin
      code_set[i]   = 4'd0;
      code_typed[i] = 4'd0;
    end
    digit_cnt    = 0;
    entry_st     = 1'b0;
    led_st       = 1'b0;
    buzzer_st    = 1'b0;
    mic_st       = 1'b0;
    backlight_st = 1'b1;
    near_limit   = NEAR_LIMIT_RESET;
  endtask

  // check each result word against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_panel.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: %s", show_panel(out_word));
      end else begin
        want = expected_panel.pop_front();
        if (out_word.alarm_mode !== want.alarm_mode || out_word.led_on !== want.led_on ||
            out_word.buzzer_on !== want.buzzer_on || out_word.mic_enabled !== want.mic_enabled ||
            out_word.backlight !== want.backlight || out_word.digit_taken !== want.digit_taken ||
            out_word.code_wrong !== want.code_wrong || out_word.entry_open !== want.entry_open)
        begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %s, got %s", show_panel(want), show_panel(out_word));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("keypad_alarm_controller_top test failed");
        $finish;
      end
    end
  end

  // result side: random stall bursts, or one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
        out_stall = 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_word(in_item_t w);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_word = w;
    do @(posedge clk); while (in_stall);
    expected_panel.push_back(predict_panel(w));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_event(logic [2:0] kind);
    in_item_t w;
    w.kind = kind;
    w.key_index = 4'($urandom);
    w.echo_width_us = 16'($urandom);
    send_word(w);
  endtask

  task automatic send_key(logic [3:0] key);
    in_item_t w;
    w.kind = KIND_KEY;
    w.key_index = key;
    w.echo_width_us = 16'($urandom);
    send_word(w);
  endtask

  task automatic send_echo(logic [15:0] width);
    in_item_t w;
    w.kind = KIND_ECHO;
    w.key_index = 4'($urandom);
    w.echo_width_us = width;
    send_word(w);
  endtask

  task automatic send_noise();
    in_item_t w;
    case ($urandom_range(0, 5))
      0: send_event(KIND_TICK);
      1: send_event(KIND_SOUND);
      2: send_echo(16'($urandom));
      3: send_event(3'($urandom_range(5, 7)));
      4: send_key(pick_non_digit_key());
      default: begin
        w = in_item_t'(23'($urandom));
        send_word(w);
      end
    endcase
  endtask

  task automatic enter_code(logic match, int noise_pct);
    logic [3:0] d;
    int         i;
    send_key(KEY_A);
    for (i = 0; i < CODE_LEN; i++) begin
      if ($urandom_range(1, 100) <= noise_pct) send_noise();
      d = match ? code_set[i] : 4'($urandom_range(0, 9));
      send_key(digit_key(d));
    end
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (expected_panel.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_near_limit(logic [15:0] v);
    drain();
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    near_limit = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random_phrase();
    int r;
    int width;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      enter_code($urandom_range(0, 3) != 0, 10);
    end else if (r < 57) begin
      send_event(KIND_SOUND);
    end else if (r < 72) begin
      if ($urandom_range(0, 1)) begin
        send_echo(16'($urandom));
      end else begin
        width = int'(near_limit) + $urandom_range(0, 6) - 3;
        if (width < 0) width = 0;
        if (width > 65535) width = 65535;
        send_echo(16'(width));
      end
    end else if (r < 84) begin
      repeat ($urandom_range(1, 4)) send_event(KIND_TICK);
    end else if (r < 92) begin
      send_event(KIND_IDLE);
    end else begin
      send_noise();
    end
  endtask

  task automatic test_code_setup();
    send_event(KIND_SOUND);
    send_event(KIND_TICK);
    send_event(KIND_IDLE);
    send_event(KIND_IDLE);
    send_event(KIND_SPARE);
    send_key(KEY_A);
    send_key(KEY_STAR);
    send_echo(16'd0);
    send_key(digit_key(4'd9));
    send_key(digit_key(4'd0));
    send_key(digit_key(4'd5));
    send_key(digit_key(4'd1));
  endtask

  task automatic test_entry_and_trigger();
    send_key(digit_key(4'd0));
    send_key(KEY_A);
    send_key(KEY_A);
    repeat (CODE_LEN) send_key(digit_key(4'd0));
    enter_code(1'b1, 0);
    send_echo(16'hffff);
    send_echo(NEAR_LIMIT_RESET);
    send_event(KIND_TICK);
    send_event(KIND_TICK);
    send_key(KEY_A);
    send_key(digit_key(4'd9));
    send_event(KIND_IDLE);
    enter_code(1'b1, 0);
    send_key(KEY_HASH);
    send_key(KEY_D);
  endtask

  task automatic test_echo_limit();
    write_near_limit(16'd0);
    enter_code(1'b1, 0);
    send_echo(16'd1);
    send_echo(16'd0);
    enter_code(1'b1, 0);
    write_near_limit(16'hffff);
    enter_code(1'b1, 0);
    send_echo(16'hffff);
    enter_code(1'b1, 0);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (8) send_noise();
    enter_code(1'b1, 0);
    enter_code(1'b0, 0);
    drain();
  endtask

  task automatic test_random_traffic();
    int phase;
    int phase_end;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       write_near_limit(16'($urandom));
        1:       write_near_limit(16'($urandom_range(0, 2000)));
        2:       write_near_limit(16'($urandom_range(65000, 65535)));
        default: write_near_limit(NEAR_LIMIT_RESET);
      endcase
      if (phase == 3) idling_on = 1'b0;
      phase_end = words_sent + (ITEM_TARGET - words_sent) / (4 - phase);
      while (words_sent < phase_end) send_random_phrase();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    reset_panel();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_code_setup();
    test_entry_and_trigger();
    test_echo_limit();
    test_backpressure();
    test_random_traffic();

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_panel.size() == 0) begin
      $display("keypad_alarm_controller_top test passed");
    end else begin
      $display("keypad_alarm_controller_top test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/kpa_pkg.sv
hdl/kpa_core.sv
hdl/keypad_alarm_controller_top.sv
hdl/kpa_checker.sv
tb/keypad_alarm_controller_top_test.sv
